>>> hdl/ttve_pkg.sv
`timescale 1ns / 1ps
package ttve_pkg;
	localparam logic [1:0] ST_FIRST  = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_SMALL  = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;
	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_MINDT = 1'b1;
	localparam int DIV_BITS = 74;
	localparam int MUL_BITS = 41;

	// command to the serial divider: signed numerator, unsigned divisor
	typedef struct packed {
		logic        start;
		logic [73:0] num;
		logic [31:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	// command to the serial blender: a*fresh + (256-a)*old
	typedef struct packed {
		logic        start;
		logic [31:0] fresh;
		logic [31:0] old;
		logic [8:0]  alpha;
	} mix_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} mix_rsp_t;
endpackage

>>> hdl/ttve_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle: sat32(num / den) toward zero.
module ttve_div
	import ttve_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_rsp_t rsp
);
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic [31:0] res_q;
	logic        neg_q;
	logic [72:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [72:0] mag;
	logic        big;
	logic [31:0] sat;

	assign rsp = '{done: done_q, quo: res_q};
	assign trial = {rem_q[31:0], quo_q[72]} - {1'b0, den_q};
	assign mag = cmd.num[73] ? 73'(-cmd.num) : cmd.num[72:0];
	always_comb begin
		big = |quo_q[72:32] || (neg_q ? quo_q[31:0] > 32'h8000_0000 : quo_q[31]);
		if (big)
			sat = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			sat = neg_q ? -quo_q[31:0] : quo_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd73;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= cmd.den;
			neg_q <= cmd.num[73];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[71:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[72]};
				quo_q <= {quo_q[71:0], 1'b0};
			end
		end
		// quotient is final once the last step is done
		if (fin_q)
			res_q <= sat;
	end
endmodule

>>> hdl/ttve_mix.sv
`timescale 1ns / 1ps
// Shift-add blender: one alpha bit a cycle, then floor divide by 256.
module ttve_mix
	import ttve_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mix_cmd_t cmd,
	output mix_rsp_t rsp
);
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] res_q;
	logic [8:0]  a_q;
	logic [8:0]  b_q;
	logic [40:0] fr_q;
	logic [40:0] ol_q;
	logic [40:0] acc_q;
	logic [40:0] nxt;

	assign rsp = '{done: done_q, res: res_q};

	always_comb begin
		nxt = acc_q;
		if (a_q[0]) nxt = nxt + fr_q;
		if (b_q[0]) nxt = nxt + ol_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd9;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= cmd.alpha;
			b_q <= 9'd256 - cmd.alpha;
			fr_q <= {{9{cmd.fresh[31]}}, cmd.fresh};
			ol_q <= {{9{cmd.old[31]}}, cmd.old};
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= nxt;
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
			fr_q <= fr_q << 1;
			ol_q <= ol_q << 1;
		end
		// arithmetic shift gives the floor
		if (busy_q && cnt_q == 4'd1)
			res_q <= nxt[39:8];
		else if (cmd.start)
			res_q <= '0;
	end
endmodule

>>> hdl/target_track_velocity_estimator_core.sv
`timescale 1ns / 1ps
// An update on a track with velocity history runs four 73-step divides and four
// blends; an update without history runs two divides; a first or ignored report
// and an id out of range use neither unit.
// Throughput: one word at a time; the next is taken the cycle after the result
// leaves, so the bit-serial divider and blender set the pace.
// Reset: arst_n clears track flags, count, control state; alpha 128, min step 1.
module target_track_velocity_estimator_core
	import ttve_pkg::*;
#(
	parameter int MAX_TARGETS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   target_id,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]  time_ms,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   status,
	output logic [7:0]   track_id,
	output logic signed [31:0] track_x,
	output logic signed [31:0] track_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] acc_x,
	output logic signed [31:0] acc_y,
	output logic [4:0]   target_count,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [9:0]   cfg_data
);
	localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_DEC = 4'd2,
		S_VX = 4'd3, S_VY = 4'd4, S_MVX = 4'd5, S_MVY = 4'd6, S_AX = 4'd7,
		S_AY = 4'd8, S_MAX = 4'd9, S_MAY = 4'd10, S_WR = 4'd11, S_OUT = 4'd12;

	logic [31:0] sx_mem [MAX_TARGETS];
	logic [31:0] sy_mem [MAX_TARGETS];
	logic [31:0] vx_mem [MAX_TARGETS];
	logic [31:0] vy_mem [MAX_TARGETS];
	logic [31:0] ax_mem [MAX_TARGETS];
	logic [31:0] ay_mem [MAX_TARGETS];
	logic [31:0] lt_mem [MAX_TARGETS];
	logic [MAX_TARGETS-1:0] hp_q, hv_q;

	logic [3:0]  state_q;
	logic [8:0]  alpha_q;
	logic [9:0]  mindt_q;
	logic [8:0]  count_q;
	logic [7:0]  id_q;
	logic [IW-1:0] ix;
	logic [31:0] nx_q, ny_q, t_q;
	logic [31:0] sx_q, sy_q, vx_q, vy_q, ax_q, ay_q, lt_q;
	logic [31:0] rx_q, ry_q, qa_q;
	logic        hp_r, hv_r;
	logic [1:0]  st_q;
	logic        out_valid_q;
	logic [8:0]  a_eff;
	logic        dstart_q, mstart_q;
	logic [73:0] dnum_q;
	logic [31:0] dden_q;
	logic [31:0] mfresh_q, mold_q;
	logic [8:0]  malpha_q;
	div_cmd_t    dcmd;
	div_rsp_t    drsp;
	mix_cmd_t    mcmd;
	mix_rsp_t    mrsp;
	logic [31:0] dt_w;

	assign ix = id_q[IW-1:0];
	assign a_eff = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
	assign dt_w = t_q - lt_q;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign dcmd = '{start: dstart_q, num: dnum_q, den: dden_q};
	assign mcmd = '{start: mstart_q, fresh: mfresh_q, old: mold_q, alpha: malpha_q};

	ttve_div u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .rsp(drsp));
	ttve_mix u_mix (.clk(clk), .arst_n(arst_n), .cmd(mcmd), .rsp(mrsp));

	function automatic logic [73:0] scale(input logic [32:0] d);
		logic [73:0] e;
		e = {{41{d[32]}}, d};
		return (e << 10) - (e << 4) - (e << 3);
	endfunction

	// launch units on state entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstart_q <= 1'b0;
			mstart_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			mstart_q <= 1'b0;
			case (state_q)
				S_DEC: if (st_q != ST_RANGE && hp_r
						&& !(t_q < lt_q || dt_w <= {22'd0, mindt_q})) dstart_q <= 1'b1;
				S_VX: if (drsp.done) dstart_q <= 1'b1;
				S_VY: if (drsp.done && hv_r) mstart_q <= 1'b1;
				S_MVX: if (mrsp.done) mstart_q <= 1'b1;
				S_MVY: if (mrsp.done) dstart_q <= 1'b1;
				S_AX: if (drsp.done) dstart_q <= 1'b1;
				S_AY: if (drsp.done) mstart_q <= 1'b1;
				S_MAX: if (mrsp.done) mstart_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dden_q <= dt_w;
		malpha_q <= a_eff;
		case (state_q)
			S_DEC: dnum_q <= scale({nx_q[31], nx_q} - {sx_q[31], sx_q});
			S_VX: if (drsp.done) dnum_q <= scale({ny_q[31], ny_q} - {sy_q[31], sy_q});
			S_VY: begin mfresh_q <= rx_q; mold_q <= vx_q; end
			S_MVX: begin
				if (mrsp.done) mfresh_q <= ry_q;
				mold_q <= vy_q;
			end
			S_MVY: dnum_q <= scale({rx_q[31], rx_q} - {vx_q[31], vx_q});
			S_AX: if (drsp.done) dnum_q <= scale({ry_q[31], ry_q} - {vy_q[31], vy_q});
			S_AY: if (drsp.done) begin mfresh_q <= qa_q; mold_q <= ax_q; end
			S_MAX: if (mrsp.done) begin mfresh_q <= qa_q; mold_q <= ay_q; end
			default: ;
		endcase
	end

	// rx/ry hold raw quotients, then smoothed results; qa holds raw accel
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			id_q <= target_id; nx_q <= pos_x; ny_q <= pos_y; t_q <= time_ms;
		end
		if (state_q == S_READ) begin
			sx_q <= sx_mem[ix]; sy_q <= sy_mem[ix];
			// a track with no velocity yet reads zero motion
			vx_q <= hv_q[ix] ? vx_mem[ix] : '0;
			vy_q <= hv_q[ix] ? vy_mem[ix] : '0;
			ax_q <= hv_q[ix] ? ax_mem[ix] : '0;
			ay_q <= hv_q[ix] ? ay_mem[ix] : '0;
			lt_q <= lt_mem[ix]; hp_r <= hp_q[ix]; hv_r <= hv_q[ix];
		end
		if (state_q == S_VX && drsp.done) rx_q <= drsp.quo;
		if (state_q == S_VY && drsp.done) ry_q <= drsp.quo;
		if (state_q == S_MVX && mrsp.done) rx_q <= mrsp.res;
		if (state_q == S_MVY && mrsp.done) ry_q <= mrsp.res;
		if (state_q == S_AX && drsp.done) qa_q <= drsp.quo;
		if (state_q == S_AY && drsp.done) qa_q <= drsp.quo;
		if (state_q == S_MAX && mrsp.done) ax_q <= mrsp.res;
		if (state_q == S_MAY && mrsp.done) ay_q <= mrsp.res;
		if (state_q == S_WR && st_q != ST_SMALL) begin
			sx_mem[ix] <= nx_q; sy_mem[ix] <= ny_q; lt_mem[ix] <= t_q;
			if (st_q == ST_UPDATE) begin
				vx_mem[ix] <= rx_q; vy_mem[ix] <= ry_q;
				ax_mem[ix] <= ax_q; ay_mem[ix] <= ay_q;
			end
		end
		if (state_q == S_WR || (state_q == S_DEC && st_q == ST_RANGE)) begin
			status <= st_q;
			track_id <= id_q;
			if (st_q == ST_RANGE) begin
				track_x <= '0; track_y <= '0; vel_x <= '0; vel_y <= '0;
				acc_x <= '0; acc_y <= '0;
			end else begin
				track_x <= (st_q == ST_SMALL) ? sx_q : nx_q;
				track_y <= (st_q == ST_SMALL) ? sy_q : ny_q;
				vel_x <= (st_q == ST_UPDATE) ? rx_q : vx_q;
				vel_y <= (st_q == ST_UPDATE) ? ry_q : vy_q;
				acc_x <= ax_q; acc_y <= ay_q;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alpha_q <= 9'd128;
			mindt_q <= 10'd1;
			count_q <= '0;
			hp_q <= '0;
			hv_q <= '0;
			st_q <= ST_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ALPHA) alpha_q <= cfg_data[8:0];
				else mindt_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: begin
					state_q <= S_DEC;
					st_q <= ({24'd0, id_q} >= 32'(MAX_TARGETS)) ? ST_RANGE : ST_FIRST;
				end
				S_DEC: begin
					if (st_q == ST_RANGE) begin
						state_q <= S_OUT; out_valid_q <= 1'b1;
					end else begin
						if (count_q <= {1'b0, id_q}) count_q <= {1'b0, id_q} + 9'd1;
						if (!hp_r) begin
							st_q <= ST_FIRST; state_q <= S_WR;
						end else if (t_q < lt_q || dt_w <= {22'd0, mindt_q}) begin
							st_q <= ST_SMALL; state_q <= S_WR;
						end else begin
							st_q <= ST_UPDATE; state_q <= S_VX;
						end
					end
				end
				S_VX: if (drsp.done) state_q <= S_VY;
				S_VY: if (drsp.done) state_q <= hv_r ? S_MVX : S_WR;
				S_MVX: if (mrsp.done) state_q <= S_MVY;
				S_MVY: if (mrsp.done) state_q <= S_AX;
				S_AX: if (drsp.done) state_q <= S_AY;
				S_AY: if (drsp.done) state_q <= S_MAX;
				S_MAX: if (mrsp.done) state_q <= S_MAY;
				S_MAY: if (mrsp.done) state_q <= S_WR;
				S_WR: begin
					if (st_q != ST_SMALL) hp_q[ix] <= 1'b1;
					if (st_q == ST_UPDATE) hv_q[ix] <= 1'b1;
					state_q <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid_q <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// count is already raised by the time the word is written
	always_ff @(posedge clk) begin
		if (state_q == S_WR || (state_q == S_DEC && st_q == ST_RANGE))
			target_count <= count_q[4:0];
	end
endmodule

>>> dv/target_track_velocity_estimator_core_test.sv
`timescale 1ns / 1ps
module target_track_velocity_estimator_core_test;
	import ttve_pkg::*;

	localparam int NTRK       = 16;
	localparam int STALL_PCT  = 17;
	localparam int WDOG_LIMIT = 6000;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  track_id;
		logic [31:0] track_x;
		logic [31:0] track_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] acc_x;
		logic [31:0] acc_y;
		logic [4:0]  target_count;
	} track_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  target_id;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0] time_ms;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  track_id;
	logic signed [31:0] track_x;
	logic signed [31:0] track_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] acc_x;
	logic signed [31:0] acc_y;
	logic [4:0]  target_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [9:0]  cfg_data;

	target_track_velocity_estimator_core dut (.*);

	// track table mirror
	int          mx [NTRK];
	int          my [NTRK];
	int          mvx [NTRK];
	int          mvy [NTRK];
	int          max_ [NTRK];
	int          may [NTRK];
	logic [31:0] mt [NTRK];
	bit          mpos [NTRK];
	bit          mvel [NTRK];
	int          mcount;
	int          alpha_reg;
	int          min_dt_reg;

	track_word_t pending_tracks[$];
	int          errors;
	int          wdog;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int per_second(longint diff, logic [31:0] dt);
		return sat32((diff * 1000) / longint'({32'b0, dt}));
	endfunction

	function automatic int smooth(int fresh, int old, int a);
		longint s;
		s = longint'(a) * fresh + longint'(256 - a) * old;
		if (s >= 0) return int'(s / 256);
		return int'(-((-s + 255) / 256));
	endfunction

	function automatic track_word_t track_update(logic [7:0] id, int nx, int ny,
			logic [31:0] t);
		track_word_t w;
		int a, vx, vy, i;
		logic [31:0] dt;
		a = (alpha_reg > 256) ? 256 : alpha_reg;
		w = '0;
		w.track_id = id;
		if (id >= NTRK) begin
			w.status = ST_RANGE;
			w.target_count = mcount[4:0];
			return w;
		end
		i = id;
		if (!mpos[i]) begin
			mx[i] = nx; my[i] = ny; mt[i] = t; mpos[i] = 1'b1;
			w.status = ST_FIRST;
		end else if (t < mt[i] || (t - mt[i]) <= min_dt_reg) begin
			w.status = ST_SMALL;
		end else begin
			dt = t - mt[i];
			vx = per_second(longint'(nx) - mx[i], dt);
			vy = per_second(longint'(ny) - my[i], dt);
			if (mvel[i]) begin
				vx = smooth(vx, mvx[i], a);
				vy = smooth(vy, mvy[i], a);
				max_[i] = smooth(per_second(longint'(vx) - mvx[i], dt), max_[i], a);
				may[i] = smooth(per_second(longint'(vy) - mvy[i], dt), may[i], a);
			end
			mvx[i] = vx; mvy[i] = vy; mvel[i] = 1'b1;
			mx[i] = nx; my[i] = ny; mt[i] = t;
			w.status = ST_UPDATE;
		end
		if (mcount < i + 1) mcount = i + 1;
		w.track_x = mx[i];
		w.track_y = my[i];
		w.vel_x = mvx[i];
		w.vel_y = mvy[i];
		w.acc_x = max_[i];
		w.acc_y = may[i];
		w.target_count = mcount[4:0];
		return w;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) report(what, got, want);
	endtask

	// sample at the falling edge: the word moves at the following rising edge
	always @(negedge clk) begin
		track_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tracks.size() == 0) begin
				report("unexpected word, track_id", track_id, 'x);
			end else begin
				w = pending_tracks.pop_front();
				check_field("status", status, w.status);
				check_field("track_id", track_id, w.track_id);
				check_field("track_x", track_x, w.track_x);
				check_field("track_y", track_y, w.track_y);
				check_field("vel_x", vel_x, w.vel_x);
				check_field("vel_y", vel_y, w.vel_y);
				check_field("acc_x", acc_x, w.acc_x);
				check_field("acc_y", acc_y, w.acc_y);
				check_field("target_count", target_count, w.target_count);
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready) || !arst_n)
			wdog = 0;
		else
			wdog++;
		if (wdog >= WDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
	end

	task automatic send_report(logic [7:0] id, logic [31:0] x, logic [31:0] y,
			logic [31:0] t);
		if (!calm && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		target_id <= id;
		pos_x     <= x;
		pos_y     <= y;
		time_ms   <= t;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		pending_tracks.push_back(track_update(id, x, y, t));
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_tracks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [9:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		if (idx == REG_ALPHA) alpha_reg = data & 10'h1ff;
		else min_dt_reg = data;
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_report(8'd0, 32'h80000000, 32'h80000000, 32'd100);
		send_report(8'd15, 32'h7fffffff, 32'h7fffffff, 32'd0);
		send_report(8'd16, 32'h12345678, 32'h9abcdef0, 32'd5);
		send_report(8'd255, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_report(8'd0, 32'd0, 32'd0, 32'd101);                // step equal to minimum
		send_report(8'd0, 32'd0, 32'd0, 32'd50);                 // time runs backwards
		send_report(8'd0, 32'h7fffffff, 32'h7fffffff, 32'd102);  // saturating velocity
		send_report(8'd0, 32'h80000000, 32'h80000000, 32'd105);
		send_report(8'd0, 32'h00010000, 32'hffff0000, 32'd110);
		send_report(8'd15, 32'h80000000, 32'h80000000, 32'hffffffff);
		send_report(8'd7, 32'h00020000, 32'h00030000, 32'd1000);
		send_report(8'd7, 32'h00028000, 32'h00024000, 32'd1100);
		send_report(8'd7, 32'h00030000, 32'h00010000, 32'd1200);
		write_reg(REG_MINDT, 10'd0);
		write_reg(REG_ALPHA, 10'd300);  // above 256, acts as full weight
		send_report(8'd3, 32'h7fff0000, 32'h80010000, 32'd1000);
		send_report(8'd3, 32'h80010000, 32'h7fff0000, 32'd1001);
		send_report(8'd3, 32'h7fff0000, 32'h80010000, 32'd1002);
		send_report(8'd3, 32'h7fff0000, 32'h80010000, 32'd1002);  // zero step
		send_report(8'd3, 32'h00000000, 32'h00000000, 32'd1003);
	endtask

	task automatic test_random(int count, int alpha, int min_dt);
		logic [7:0]  id;
		logic [31:0] x, y, t;
		int          p, i;
		write_reg(REG_ALPHA, alpha[9:0]);
		write_reg(REG_MINDT, min_dt[9:0]);
		for (int n = 0; n < count; n++) begin
			calm = (n >= count / 3) && (n < count / 3 + 40);
			id = ($urandom_range(99) < 8) ? 8'($urandom_range(16, 255))
					: 8'($urandom_range(0, NTRK - 1));
			i = id % NTRK;
			p = $urandom_range(99);
			if (p < 70) begin
				x = mx[i] + $signed($urandom_range(0, 2097152)) - 1048576;
				y = my[i] + $signed($urandom_range(0, 2097152)) - 1048576;
			end else if (p < 88) begin
				x = $urandom; y = $urandom;
			end else begin
				x = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
				y = $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
			end
			p = $urandom_range(99);
			if (p < 78) t = mt[i] + min_dt_reg + $urandom_range(1, 60);
			else if (p < 88) t = mt[i] + $urandom_range(0, min_dt_reg);
			else if (p < 94) t = mt[i] - $urandom_range(1, 500);
			else t = $urandom;
			send_report(id, x, y, t);
		end
		calm = 1'b0;
	endtask

	initial begin
		errors = 0;
		wdog = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_id = '0;
		pos_x = '0;
		pos_y = '0;
		time_ms = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ALPHA;
		cfg_data = '0;
		for (int i = 0; i < NTRK; i++) begin
			mx[i] = 0; my[i] = 0; mvx[i] = 0; mvy[i] = 0;
			max_[i] = 0; may[i] = 0; mt[i] = '0; mpos[i] = 0; mvel[i] = 0;
		end
		mcount = 0;
		alpha_reg = 128;
		min_dt_reg = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(180, 128, 5);
		test_random(130, 0, 1000);
		test_random(130, 511, 0);
		test_random(110, 256, 3);
		test_random(100, 37, 1);

		drain();
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> sim.f
hdl/ttve_pkg.sv
hdl/ttve_div.sv
hdl/ttve_mix.sv
hdl/target_track_velocity_estimator_core.sv
dv/target_track_velocity_estimator_core_test.sv
